FILE: design/ppz_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the point projection depth store
package ppz_pkg;

  localparam int ACC_W   = 52;
  localparam int COEF_W  = 32;
  localparam int CRD_W   = 18;
  localparam int DEPTH_W = 18;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int IMW_W   = 11;
  localparam int IMH_W   = 10;
  localparam int CFG_W   = 64;
  localparam int CFG_AW  = 3;
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic [CFG_AW-1:0] REG_U_XY  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_U_ZT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_V_XY  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_V_ZT  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_W_XY  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_W_ZT  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_IMG_W = 3'd6;
  localparam logic [CFG_AW-1:0] REG_IMG_H = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0] u_xy;
    logic [CFG_W-1:0] u_zt;
    logic [CFG_W-1:0] v_xy;
    logic [CFG_W-1:0] v_zt;
    logic [CFG_W-1:0] w_xy;
    logic [CFG_W-1:0] w_zt;
  } coef_t;

  typedef struct packed {
    logic                    func;
    logic signed [ACC_W-1:0] au;
    logic signed [ACC_W-1:0] av;
    logic signed [ACC_W-1:0] aw;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: design/ppz_front.sv
`timescale 1ns / 1ps
// front end: accepts beats and forms the three projection sums
module ppz_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic signed [ppz_pkg::CRD_W-1:0]    point_x,
  input  logic signed [ppz_pkg::CRD_W-1:0]    point_y,
  input  logic signed [ppz_pkg::CRD_W-1:0]    point_z,
  input  logic [ppz_pkg::COL_W-1:0]           pixel_col,
  input  logic [ppz_pkg::ROW_W-1:0]           pixel_row,
  input  ppz_pkg::coef_t                      coef,
  input  ppz_pkg::qstat_t                     qstat,
  output logic                                push,
  output ppz_pkg::entry_t                     entry
);
  import ppz_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MAC  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam int PW = COEF_W + CRD_W;

  logic [1:0] state;
  logic [1:0] cnt;
  logic       pv;
  logic       is_read;
  logic signed [CRD_W-1:0]  px, py, pz, dsel;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic signed [COEF_W-1:0] cx [3];
  logic signed [COEF_W-1:0] cy [3];
  logic signed [COEF_W-1:0] cz [3];
  logic signed [COEF_W-1:0] ct [3];
  logic signed [COEF_W-1:0] csel [3];
  logic signed [PW-1:0]     prod [3];
  logic signed [ACC_W-1:0]  acc [3];

  always_comb begin
    cx[0] = coef.u_xy[31:0];  cy[0] = coef.u_xy[63:32];
    cz[0] = coef.u_zt[31:0];  ct[0] = coef.u_zt[63:32];
    cx[1] = coef.v_xy[31:0];  cy[1] = coef.v_xy[63:32];
    cz[1] = coef.v_zt[31:0];  ct[1] = coef.v_zt[63:32];
    cx[2] = coef.w_xy[31:0];  cy[2] = coef.w_xy[63:32];
    cz[2] = coef.w_zt[31:0];  ct[2] = coef.w_zt[63:32];
  end

  // one term per cycle: x, then y, then z
  always_comb begin
    case (cnt)
      2'd0: dsel = px;
      2'd1: dsel = py;
      default: dsel = pz;
    endcase
    for (int r = 0; r < 3; r++) begin
      case (cnt)
        2'd0: csel[r] = cx[r];
        2'd1: csel[r] = cy[r];
        default: csel[r] = cz[r];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
      pv    <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) begin
          state <= func ? F_PUSH : F_MAC;
          cnt   <= '0;
          pv    <= 1'b0;
        end
        F_MAC: begin
          cnt <= cnt + 2'd1;
          pv  <= (cnt != 2'd3);
          if (cnt == 2'd3) state <= F_PUSH;
        end
        F_PUSH: if (!qstat.full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      is_read <= func;
      px      <= point_x;
      py      <= point_y;
      pz      <= point_z;
      col     <= pixel_col;
      row     <= pixel_row;
      for (int r = 0; r < 3; r++) begin
        acc[r] <= {{(ACC_W-COEF_W){ct[r][COEF_W-1]}}, ct[r]};
      end
    end
    if (state == F_MAC) begin
      for (int r = 0; r < 3; r++) begin
        prod[r] <= csel[r] * dsel;
        if (pv) acc[r] <= acc[r] + {{(ACC_W-PW){prod[r][PW-1]}}, prod[r]};
      end
    end
  end

  assign in_stall   = rst || (state != F_IDLE);
  assign push       = (state == F_PUSH) && !qstat.full;
  assign entry.func = is_read;
  assign entry.au   = acc[0];
  assign entry.av   = acc[1];
  assign entry.aw   = acc[2];
  assign entry.col  = col;
  assign entry.row  = row;

endmodule

FILE: design/ppz_fifo.sv
`timescale 1ns / 1ps
// short queue between the front and back ends
module ppz_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ppz_pkg::entry_t  din,
  input  logic             pop,
  output ppz_pkg::entry_t  dout,
  output ppz_pkg::qstat_t  stat
);
  import ppz_pkg::*;

  entry_t          slots [Q_DEPTH];
  logic [Q_PW-1:0] wp, rp;
  logic [Q_PW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (Q_PW+1)'(push) - (Q_PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

  assign dout       = slots[rp];
  assign stat.full  = (count == (Q_PW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

FILE: design/ppz_back.sv
`timescale 1ns / 1ps
// back end: pixel division, window test and depth store update
module ppz_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int BORDER     = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppz_pkg::entry_t                   head,
  input  ppz_pkg::qstat_t                   qstat,
  output logic                              pop,
  input  logic [ppz_pkg::IMW_W-1:0]         image_width,
  input  logic [ppz_pkg::IMH_W-1:0]         image_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ppz_pkg::DEPTH_W-1:0]       depth,
  output logic                              in_view,
  output logic                              nearer
);
  import ppz_pkg::*;

  localparam int LIM     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QB      = $clog2(LIM + 1);
  localparam int DW      = ACC_W + QB;
  localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(QB);
  localparam int HW      = ACC_W - 16;

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_CHK  = 3'd3;
  localparam logic [2:0] B_RD   = 3'd4;
  localparam logic [2:0] B_CMP  = 3'd5;
  localparam logic [2:0] B_FIN  = 3'd6;

  logic [DEPTH_W-1:0] store [ENTRIES];

  logic [2:0]         state;
  logic [AW-1:0]      clr_addr, addr, waddr;
  logic [CW-1:0]      dcnt;
  logic               is_read, bad_u, bad_v;
  logic [DW-1:0]      rem_u, rem_v, dsh;
  logic [QB-1:0]      q_u, q_v, w_lim, h_lim;
  logic [DEPTH_W-1:0] dnew, rdata, wdata, res_depth;
  logic               res_view, res_near;
  logic               we, near, win_ok, rd_ok, aw_pos;
  logic [DW-1:0]      nu_ext, nv_ext, dw_sh;
  logic [HW-1:0]      dhi;
  logic [DEPTH_W-1:0] dsat;

  // operands as the head entry is taken
  always_comb begin
    nu_ext = DW'(unsigned'(head.au));
    nv_ext = DW'(unsigned'(head.av));
    dw_sh  = {head.aw, {QB{1'b0}}};
    aw_pos = !head.aw[ACC_W-1] && (head.aw != '0);
    dhi    = head.aw[ACC_W-1:16];
    if (dhi > HW'(DEPTH_MAX)) dsat = DEPTH_MAX;
    else if (dhi == '0) dsat = DEPTH_W'(1);
    else dsat = dhi[DEPTH_W-1:0];
    rd_ok  = (int'(head.col) < MAX_WIDTH) && (int'(head.row) < MAX_HEIGHT);
  end

  always_comb begin
    w_lim  = (int'(image_width) > MAX_WIDTH) ? QB'(MAX_WIDTH) : QB'(image_width);
    h_lim  = (int'(image_height) > MAX_HEIGHT) ? QB'(MAX_HEIGHT) : QB'(image_height);
    win_ok = !bad_u && !bad_v &&
             int'(q_u) > BORDER && int'(q_u) <= int'(w_lim) - BORDER && q_u < w_lim &&
             int'(q_v) > BORDER && int'(q_v) <= int'(h_lim) - BORDER && q_v < h_lim;
    near   = (rdata == '0) || (dnew < rdata);
  end

  assign pop = (state == B_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_addr  <= '0;
    end else begin
      unique case (state)
        B_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(ENTRIES - 1)) state <= B_IDLE;
        end
        B_IDLE: if (!qstat.empty) begin
          if (head.func) state <= rd_ok ? B_RD : B_FIN;
          else state <= aw_pos ? B_DIV : B_FIN;
        end
        B_DIV: if (dcnt == CW'(QB - 1)) state <= B_CHK;
        B_CHK: state <= win_ok ? B_RD : B_FIN;
        B_RD:  state <= B_CMP;
        B_CMP: state <= B_FIN;
        B_FIN: if (!out_valid || !out_stall) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == B_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        is_read   <= head.func;
        res_depth <= '0;
        res_view  <= 1'b0;
        res_near  <= 1'b0;
        dnew      <= dsat;
        rem_u     <= nu_ext;
        rem_v     <= nv_ext;
        dsh       <= dw_sh >> 1;
        q_u       <= '0;
        q_v       <= '0;
        dcnt      <= '0;
        // quotient beyond the counter width can never land in the image
        bad_u     <= head.au[ACC_W-1] || (nu_ext >= dw_sh);
        bad_v     <= head.av[ACC_W-1] || (nv_ext >= dw_sh);
        addr      <= AW'(int'(head.row) * MAX_WIDTH + int'(head.col));
      end
      B_DIV: begin
        dcnt <= dcnt + 1'b1;
        dsh  <= dsh >> 1;
        if (rem_u >= dsh) begin
          rem_u <= rem_u - dsh;
          q_u   <= {q_u[QB-2:0], 1'b1};
        end else begin
          q_u <= {q_u[QB-2:0], 1'b0};
        end
        if (rem_v >= dsh) begin
          rem_v <= rem_v - dsh;
          q_v   <= {q_v[QB-2:0], 1'b1};
        end else begin
          q_v <= {q_v[QB-2:0], 1'b0};
        end
      end
      B_CHK: addr <= AW'(int'(q_v) * MAX_WIDTH + int'(q_u));
      B_CMP: begin
        if (is_read) res_depth <= rdata;
        else begin
          res_view <= 1'b1;
          res_near <= near;
        end
      end
      B_FIN: if (!out_valid || !out_stall) begin
        depth   <= res_depth;
        in_view <= res_view;
        nearer  <= res_near;
      end
      default: ;
    endcase
  end

  // single write port shared by the clearing sweep and the update
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (state == B_CLR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (state == B_CMP) begin
      we    = is_read || near;
      wdata = is_read ? '0 : dnew;
    end
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    if (state == B_RD) rdata <= store[addr];
  end

endmodule

FILE: design/point_projection_depth_zbuffer_core.sv
`timescale 1ns / 1ps
// top level of the point projection depth store
// After reset the depth store is swept clear, one entry per cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries (524288 at the defaults); configuration writes are taken
// during the sweep, and up to three beats are accepted (two queued, one held in the front
// end) but none is carried out until it ends. The front end takes one beat and, for a
// projection beat, forms the three projection sums one term at a time with one multiplier
// per row, then passes them through a two-entry queue. The back end sets the rate: a
// projected point goes through the one-bit-per-cycle column and row dividers, the window
// check and the read-modify-write of the store, and a read beat through the store read.
// An output register holds each result so the back end can take the next entry and the
// front keeps accepting while a result waits, until the back end and the queue are full.
module point_projection_depth_zbuffer_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int BORDER     = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ppz_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [ppz_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic signed [ppz_pkg::CRD_W-1:0] point_x,
  input  logic signed [ppz_pkg::CRD_W-1:0] point_y,
  input  logic signed [ppz_pkg::CRD_W-1:0] point_z,
  input  logic [ppz_pkg::COL_W-1:0]        pixel_col,
  input  logic [ppz_pkg::ROW_W-1:0]        pixel_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ppz_pkg::DEPTH_W-1:0]      depth,
  output logic                             in_view,
  output logic                             nearer
);
  import ppz_pkg::*;

  coef_t            coef;
  logic [IMW_W-1:0] img_w;
  logic [IMH_W-1:0] img_h;
  qstat_t           q_stat;
  entry_t           q_in, q_out;
  logic             q_push, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef  <= '0;
      img_w <= IMW_W'(640);
      img_h <= IMH_W'(480);
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_U_XY:  coef.u_xy <= cfg_data;
        REG_U_ZT:  coef.u_zt <= cfg_data;
        REG_V_XY:  coef.v_xy <= cfg_data;
        REG_V_ZT:  coef.v_zt <= cfg_data;
        REG_W_XY:  coef.w_xy <= cfg_data;
        REG_W_ZT:  coef.w_zt <= cfg_data;
        REG_IMG_W: img_w <= cfg_data[IMW_W-1:0];
        REG_IMG_H: img_h <= cfg_data[IMH_W-1:0];
        default: ;
      endcase
    end
  end

  ppz_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .coef      (coef),
    .qstat     (q_stat),
    .push      (q_push),
    .entry     (q_in)
  );

  ppz_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .dout (q_out),
    .stat (q_stat)
  );

  ppz_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .BORDER     (BORDER)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_out),
    .qstat        (q_stat),
    .pop          (q_pop),
    .image_width  (img_w),
    .image_height (img_h),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .depth        (depth),
    .in_view      (in_view),
    .nearer       (nearer)
  );

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full) else $error("push into full queue");
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_near_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && nearer |-> in_view) else $error("nearer without in_view");
  a_proj_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_view |-> depth == '0) else $error("depth on a projection beat");
`endif

endmodule
